// ----- sv/fys_pkg.sv -----
package fys_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 10;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_RANDOM = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REJECTED = 3'd1,
    ST_SWAPPED  = 3'd2,
    ST_FINISHED = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BAD      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_LOADING   = 2'd0,
    PH_SHUFFLING = 2'd1,
    PH_DONE      = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_EFF  = 2'd1,
    RD_CAND = 2'd2,
    RD_IDX  = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LOAD = 2'd1,
    WR_POS  = 2'd2,
    WR_CAND = 2'd3
  } wr_sel_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [WORD_W-1:0]   element_value;
    logic [WORD_W-1:0]   random_word;
    logic [POS_W-1:0]    read_index;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   read_value;
    logic [POS_W-1:0]    position;
    logic                done_res;
  } result_t;

  typedef struct packed {
    logic    latch;
    logic    do_load;
    logic    do_clear;
    logic    do_start;
    logic    do_finish_empty;
    logic    do_step;
    logic    cap_cand;
    logic    cap_hold;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    emit;
    logic    sel_rdata;
    status_t status;
  } fys_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    phase_t  phase;
    logic    full;
    logic    count_le1;
    logic    idx_bad;
    logic    cand_reject;
    logic    pos_is_one;
  } fys_stat_t;

endpackage

// ----- sv/fys_ctrl.sv -----
module fys_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fys_pkg::fys_stat_t stat,
  output fys_pkg::fys_cmd_t  cmd,
  output logic              busy
);
  import fys_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SWAP_RD,
    S_SWAP_WR1,
    S_SWAP_WR2
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    cmd.wr_sel = WR_NONE;
    cmd.status = ST_ACCEPTED;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.opcode)
          OP_LOAD: begin
            cmd.emit = 1'b1;
            if (stat.phase != PH_LOADING) begin
              cmd.status = ST_BAD;
            end else if (stat.full) begin
              cmd.status = ST_OVERFLOW;
            end else begin
              cmd.do_load = 1'b1;
              cmd.wr_sel  = WR_LOAD;
            end
          end
          OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.emit     = 1'b1;
          end
          OP_READ: begin
            if (stat.idx_bad) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_BAD;
            end else begin
              cmd.rd_sel = RD_IDX;
              state_next = S_READ;
            end
          end
          OP_RANDOM: begin
            if (stat.phase == PH_DONE) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_BAD;
            end else if (stat.phase == PH_LOADING && stat.count_le1) begin
              cmd.do_finish_empty = 1'b1;
              cmd.emit            = 1'b1;
              cmd.status          = ST_FINISHED;
            end else begin
              cmd.do_start = (stat.phase == PH_LOADING);
              cmd.cap_cand = 1'b1;
              if (stat.cand_reject) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_REJECTED;
              end else begin
                cmd.rd_sel = RD_EFF;
                state_next = S_SWAP_RD;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd.emit      = 1'b1;
        cmd.sel_rdata = 1'b1;
        state_next    = S_IDLE;
      end
      S_SWAP_RD: begin
        cmd.rd_sel   = RD_CAND;
        cmd.cap_hold = 1'b1;
        state_next   = S_SWAP_WR1;
      end
      S_SWAP_WR1: begin
        cmd.wr_sel = WR_POS;
        state_next = S_SWAP_WR2;
      end
      S_SWAP_WR2: begin
        cmd.wr_sel  = WR_CAND;
        cmd.do_step = 1'b1;
        cmd.emit    = 1'b1;
        cmd.status  = stat.pos_is_one ? ST_FINISHED : ST_SWAPPED;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- sv/fys_dpath.sv -----
module fys_dpath (
  input  logic               clk,
  input  logic               rst,
  input  fys_pkg::item_t     item,
  input  fys_pkg::fys_cmd_t  cmd,
  output fys_pkg::fys_stat_t stat,
  output fys_pkg::result_t   result,
  output logic               result_valid
);
  import fys_pkg::*;

  logic [WORD_W-1:0]  mem [TABLE_DEPTH];
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  hold;
  item_t              word;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [ADDR_W-1:0]  position;
  logic [ADDR_W-1:0]  position_next;
  phase_t             phase;
  phase_t             phase_next;
  logic [ADDR_W-1:0]  cand;
  logic [ADDR_W-1:0]  eff_pos;
  logic [ADDR_W-1:0]  cover_mask;
  logic [ADDR_W-1:0]  cand_now;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               wr_en;

  // position used by a draw, before the start of the shuffle is recorded
  assign eff_pos = (phase == PH_LOADING) ? ADDR_W'(count - COUNT_W'(1)) : position;

  // smallest all-ones value covering the position
  always_comb begin
    cover_mask = eff_pos;
    for (int i = 1; i < ADDR_W; i++) begin
      cover_mask = cover_mask | (eff_pos >> i);
    end
  end

  assign cand_now = ADDR_W'(word.random_word) & cover_mask;

  always_comb begin
    stat.opcode      = word.opcode;
    stat.phase       = phase;
    stat.full        = (count >= COUNT_W'(TABLE_DEPTH));
    stat.count_le1   = (count <= COUNT_W'(1));
    stat.idx_bad     = (32'(word.read_index) >= 32'(count));
    stat.cand_reject = (cand_now > eff_pos);
    stat.pos_is_one  = (position == ADDR_W'(1));
  end

  always_comb begin
    count_next    = count;
    position_next = position;
    phase_next    = phase;
    if (cmd.do_load) begin
      count_next = count + COUNT_W'(1);
    end
    if (cmd.do_clear) begin
      count_next    = '0;
      position_next = '0;
      phase_next    = PH_LOADING;
    end
    if (cmd.do_finish_empty) begin
      position_next = '0;
      phase_next    = PH_DONE;
    end
    if (cmd.do_start) begin
      position_next = eff_pos;
      phase_next    = PH_SHUFFLING;
    end
    if (cmd.do_step) begin
      position_next = position - ADDR_W'(1);
      phase_next    = (position == ADDR_W'(1)) ? PH_DONE : PH_SHUFFLING;
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = eff_pos;
    case (cmd.rd_sel)
      RD_EFF:  rd_addr = eff_pos;
      RD_CAND: rd_addr = cand;
      RD_IDX:  rd_addr = ADDR_W'(word.read_index);
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = position;
    wr_data = rdata;
    case (cmd.wr_sel)
      WR_LOAD: begin
        wr_addr = ADDR_W'(count);
        wr_data = word.element_value;
      end
      WR_POS: begin
        wr_addr = position;
        wr_data = rdata;
      end
      WR_CAND: begin
        wr_addr = cand;
        wr_data = hold;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      word <= item;
    end
    if (cmd.cap_cand) begin
      cand <= cand_now;
    end
    if (cmd.cap_hold) begin
      hold <= rdata;
    end
    if (cmd.emit) begin
      result.status     <= cmd.status;
      result.read_value <= cmd.sel_rdata ? rdata : '0;
      result.position   <= POS_W'(position_next);
      result.done_res   <= (phase_next == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      position     <= '0;
      phase        <= PH_LOADING;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      position     <= position_next;
      phase        <= phase_next;
      result_valid <= cmd.emit;
    end
  end

endmodule

// ----- sv/fisher_yates_shuffle_engine_core.sv -----
// channel  | handshake                  | word
// ---------+----------------------------+------------------------------------------
// command  | start, busy (start & !busy)| item: opcode, element_value, random_word,
//          |                            |       read_index
// result   | result_valid, one cycle    | result: status, read_value, position,
//          |                            |         done_res
//
// load, clear and any rejected or refused word: result decided in S_DECODE, then registered
// read: adds S_READ, set by the registered table read
// accepted draw: two reads and two writes, in S_DECODE, S_SWAP_RD, S_SWAP_WR1, S_SWAP_WR2
// busy is low again in the cycle the result is shown; rst clears count, position
// and phase, the table keeps its contents; the receiver cannot stall
module fisher_yates_shuffle_engine_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fys_pkg::item_t   item,
  output logic             busy,
  output fys_pkg::result_t result,
  output logic             result_valid
);
  import fys_pkg::*;

  fys_cmd_t  cmd;
  fys_stat_t stat;

  fys_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fys_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- sim/fisher_yates_shuffle_engine_core_test.sv -----
module fisher_yates_shuffle_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fys_pkg::*;

  typedef struct {
    item_t   cmd;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  result_t result;
  logic    result_valid;

  fisher_yates_shuffle_engine_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the engine state
  logic [WORD_W-1:0]  shadow_table [TABLE_DEPTH];
  logic [COUNT_W-1:0] sh_count = '0;
  logic [POS_W-1:0]   sh_pos = '0;
  phase_t             sh_phase = PH_LOADING;

  result_t   pending_results [$];
  plan_row_t plan [$];
  result_t   oldest;
  int        idle_pct = 0;
  int        n_errors = 0;
  int        n_words = 0;
  int        n_useful = 0;
  int        n_checked = 0;
  int        n_swaps = 0;
  int        n_rejects = 0;
  int        n_overflows = 0;
  int        n_sessions = 0;
  int        biggest = 0;

  function automatic item_t mk(opcode_t op, logic [WORD_W-1:0] v, logic [WORD_W-1:0] rw,
                               logic [POS_W-1:0] ix);
    item_t w;
    w.opcode        = op;
    w.element_value = v;
    w.random_word   = rw;
    w.read_index    = ix;
    return w;
  endfunction

  function automatic result_t res(status_t st, logic [WORD_W-1:0] rv, logic [POS_W-1:0] p,
                                  logic d);
    result_t r;
    r.status     = st;
    r.read_value = rv;
    r.position   = p;
    r.done_res   = d;
    return r;
  endfunction

  function automatic result_t shuffle_outcome(item_t w);
    logic [POS_W-1:0]  m;
    logic [POS_W-1:0]  c;
    logic [WORD_W-1:0] t;
    status_t           st;
    logic [WORD_W-1:0] rv;
    st = ST_ACCEPTED;
    rv = '0;
    case (w.opcode)
      OP_LOAD: begin
        if (sh_phase != PH_LOADING) st = ST_BAD;
        else if (sh_count >= TABLE_DEPTH) st = ST_OVERFLOW;
        else begin
          shadow_table[sh_count[ADDR_W-1:0]] = w.element_value;
          sh_count = sh_count + COUNT_W'(1);
        end
      end
      OP_RANDOM: begin
        if (sh_phase == PH_LOADING) begin
          if (sh_count <= 1) begin
            sh_pos   = '0;
            sh_phase = PH_DONE;
            st       = ST_FINISHED;
          end else begin
            sh_pos   = POS_W'(sh_count - COUNT_W'(1));
            sh_phase = PH_SHUFFLING;
          end
        end else if (sh_phase != PH_SHUFFLING) begin
          st = ST_BAD;
        end
        if (sh_phase == PH_SHUFFLING) begin
          m = '0;
          while (m < sh_pos) m = {m[POS_W-2:0], 1'b1};
          c = w.random_word[POS_W-1:0] & m;
          if (c > sh_pos) begin
            st = ST_REJECTED;
          end else begin
            t                    = shadow_table[sh_pos];
            shadow_table[sh_pos] = shadow_table[c];
            shadow_table[c]      = t;
            sh_pos               = sh_pos - POS_W'(1);
            if (sh_pos == 0) begin
              sh_phase = PH_DONE;
              st       = ST_FINISHED;
            end else begin
              st = ST_SWAPPED;
            end
          end
        end
      end
      OP_READ: begin
        if (w.read_index >= sh_count) st = ST_BAD;
        else rv = shadow_table[w.read_index];
      end
      default: begin
        sh_count = '0;
        sh_pos   = '0;
        sh_phase = PH_LOADING;
      end
    endcase
    return res(st, rv, sh_pos, sh_phase == PH_DONE);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        oldest = pending_results.pop_front();
        n_checked++;
        if (result.status !== oldest.status)
          report_mismatch($sformatf("status %0d, want %0d", result.status, oldest.status));
        if (result.read_value !== oldest.read_value)
          report_mismatch($sformatf("read_value %h, want %h",
                                    result.read_value, oldest.read_value));
        if (result.position !== oldest.position)
          report_mismatch($sformatf("position %0d, want %0d", result.position, oldest.position));
        if (result.done_res !== oldest.done_res)
          report_mismatch($sformatf("done_res %b, want %b", result.done_res, oldest.done_res));
      end
    end
  end

  task automatic send_word(input item_t w);
    result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item  <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = shuffle_outcome(w);
    pending_results.push_back(r);
    n_words++;
    if (r.status != ST_BAD) n_useful++;
    if (r.status == ST_SWAPPED || r.status == ST_FINISHED) n_swaps++;
    if (r.status == ST_REJECTED) n_rejects++;
    if (r.status == ST_OVERFLOW) n_overflows++;
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] some_index();
    if (sh_count != 0 && $urandom_range(3) != 0) return POS_W'($urandom_range(sh_count - 1));
    return POS_W'($urandom);
  endfunction

  // clear, fill, shuffle until done or the budget runs out, with reads and stray words mixed in
  task automatic run_session(input int n);
    int  budget;
    int  pick;
    bit  noisy;
    noisy = (n < TABLE_DEPTH);
    send_word(mk(OP_CLEAR, $urandom, $urandom, POS_W'($urandom)));
    for (int i = 0; i < n; i++) begin
      send_word(mk(OP_LOAD, $urandom, $urandom, POS_W'($urandom)));
      if (noisy && $urandom_range(7) == 0)
        send_word(mk(OP_READ, $urandom, $urandom, some_index()));
    end
    if (!noisy) repeat (2) send_word(mk(OP_LOAD, $urandom, $urandom, POS_W'($urandom)));
    budget = noisy ? 4 * n + 8 : 64;
    while (sh_phase != PH_DONE && budget > 0) begin
      budget--;
      pick = noisy ? $urandom_range(99) : $urandom_range(89);
      if (pick < 80) send_word(mk(OP_RANDOM, $urandom, $urandom, POS_W'($urandom)));
      else if (pick < 90) send_word(mk(OP_READ, $urandom, $urandom, some_index()));
      else if (pick < 94) send_word(mk(OP_LOAD, $urandom, $urandom, POS_W'($urandom)));
      else if (pick < 96) send_word(mk(OP_CLEAR, $urandom, $urandom, POS_W'($urandom)));
      else send_word(mk(opcode_t'($urandom_range(3)), $urandom, $urandom, POS_W'($urandom)));
    end
    repeat ($urandom_range(1, 4)) send_word(mk(OP_READ, $urandom, $urandom, some_index()));
    if ($urandom_range(1) == 1)
      send_word(mk(OP_RANDOM, $urandom, $urandom, POS_W'($urandom)));
    n_sessions++;
    if (n > biggest) biggest = n;
  endtask

  initial begin
    int goal;
    plan.push_back('{mk(OP_READ, '0, '0, 10'd0), 1, res(ST_BAD, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_RANDOM, '0, '0, '0), 1, res(ST_FINISHED, '0, '0, 1'b1)});
    plan.push_back('{mk(OP_RANDOM, '0, '1, '0), 1, res(ST_BAD, '0, '0, 1'b1)});
    plan.push_back('{mk(OP_LOAD, '1, '0, '0), 1, res(ST_BAD, '0, '0, 1'b1)});
    plan.push_back('{mk(OP_READ, '0, '0, '1), 1, res(ST_BAD, '0, '0, 1'b1)});
    plan.push_back('{mk(OP_CLEAR, '1, '1, '1), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_LOAD, '1, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_RANDOM, '0, '1, '0), 1, res(ST_FINISHED, '0, '0, 1'b1)});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd0), 1, res(ST_ACCEPTED, '1, '0, 1'b1)});
    plan.push_back('{mk(OP_CLEAR, '0, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_LOAD, '0, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_LOAD, '1, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_LOAD, 32'hA5A5_A5A5, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_LOAD, 32'h5A5A_5A5A, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd3), 1, res(ST_ACCEPTED, 32'h5A5A_5A5A, '0, 1'b0)});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd4), 1, res(ST_BAD, '0, '0, 1'b0)});
    // swap with itself, then a rejected draw, then shuffle down to zero
    plan.push_back('{mk(OP_RANDOM, '0, '1, '0), 0, '0});
    plan.push_back('{mk(OP_RANDOM, '0, 32'h0000_0003, '0), 0, '0});
    plan.push_back('{mk(OP_LOAD, 32'h1, '0, '0), 0, '0});
    plan.push_back('{mk(OP_RANDOM, '0, '0, '0), 0, '0});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd2), 0, '0});
    plan.push_back('{mk(OP_RANDOM, '0, 32'hFFFF_FFFE, '0), 0, '0});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd0), 0, '0});
    plan.push_back('{mk(OP_READ, '0, '0, 10'd1), 0, '0});
    plan.push_back('{mk(OP_CLEAR, '0, '0, '0), 1, res(ST_ACCEPTED, '0, '0, 1'b0)});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_word(plan[i].cmd);
      if (plan[i].typed) pending_results[pending_results.size() - 1] = plan[i].want;
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 59 : (p == 2) ? 27 : 0;
      if (p == 1) run_session(TABLE_DEPTH);
      goal = n_useful + 30;
      while (n_useful < goal)
        run_session(($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12));
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d words in %0d shuffle sessions, largest table %0d entries",
             n_words, n_sessions, biggest);
    $display("checked %0d results: %0d swaps, %0d rejected draws, %0d overflows",
             n_checked, n_swaps, n_rejects, n_overflows);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
